[rtl/fbmeu_pkg.sv]
`timescale 1ns / 1ps

package fbmeu_pkg;

  localparam int CmdW     = 7;
  localparam int OpW      = 10;
  localparam int PcW      = 13;
  localparam int NibW     = 4;
  localparam int InDataW  = 40;
  localparam int OutDataW = 24;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RAM_FILE_MODE = 2'd0,
    CFG_RAM_ADDR_MASK = 2'd1,
    CFG_PC_MASK       = 2'd2
  } cfg_idx_e;

  typedef enum logic [CmdW-1:0] {
    CMD_ILL = 7'd0,
    CMD_LAB, CMD_LBA, CMD_LAY, CMD_LASPX, CMD_LASPY, CMD_XAMR,
    CMD_LXA, CMD_LYA, CMD_LXI, CMD_LYI, CMD_IY, CMD_DY, CMD_AYY, CMD_SYY, CMD_XSP,
    CMD_LAM, CMD_LBM, CMD_XMA, CMD_XMB, CMD_LMAIY, CMD_LMADY, CMD_LMIIY,
    CMD_LAI, CMD_LBI, CMD_AI, CMD_IB, CMD_DB, CMD_AMC, CMD_SMC, CMD_AM, CMD_DAA,
    CMD_DAS, CMD_NEGA, CMD_COMB, CMD_SEC, CMD_REC, CMD_TC, CMD_ROTL, CMD_ROTR,
    CMD_OR, CMD_MNEI, CMD_YNEI, CMD_ANEM, CMD_BNEM, CMD_ALEI, CMD_ALEM, CMD_BLEM,
    CMD_SEM, CMD_REM, CMD_TM, CMD_BR, CMD_CAL, CMD_TBR, CMD_RTN, CMD_SEIE,
    CMD_SEIF0, CMD_SEIF1, CMD_SETF, CMD_SECF, CMD_REIE, CMD_REIF0, CMD_REIF1,
    CMD_RETF, CMD_RECF, CMD_TI0, CMD_TI1, CMD_TIF0, CMD_TIF1, CMD_TTF, CMD_RTNI
  } cmd_e;

endpackage

[rtl/four_bit_mcu_execute_unit.sv]
`timescale 1ns / 1ps

// execute unit of a small 4-bit controller, one decoded instruction per transfer
// s_axis: instruction in; tdata = command, op_bits, imm, pc, int_pins (low bit up)
// m_axis: one result per instruction; tdata = next_pc, acc, breg, status_flag,
//   carry_flag, block_interrupt (low bit up)
// cfg: write enable, register index, data; write only while the unit is idle
// pipeline: an accepted instruction is registered in the execute stage, its result in the result register
// throughput: one instruction per cycle while results are taken; the data ram is read at accept time
//   with the address built from the state the instruction in flight leaves,
//   and a write at that same edge is forwarded into the read
// reset: registers, flags, return stack and config go to their reset values;
//   the data ram reads as zero through per-word valid bits, no clearing pass
// stall: when m_axis_tready is low the result holds, one more instruction
//   waits in the execute register, then s_axis_tready drops
module four_bit_mcu_execute_unit #(
  parameter int STACK_DEPTH = 4,
  parameter int RAM_WORDS   = 256,
  parameter int PC_BITS     = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // command, op_bits, imm, pc, int_pins
  input  logic [fbmeu_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // next_pc, acc, breg, status_flag, carry_flag, block_interrupt
  output logic [fbmeu_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [fbmeu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fbmeu_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fbmeu_pkg::*;

  localparam int RamAw = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam logic [PcW-1:0] PcwMask =
    (PC_BITS >= PcW) ? {PcW{1'b1}} : PcW'((1 << PC_BITS) - 1);

  function automatic logic [RamAw-1:0] ram_wrap(input logic [7:0] addr);
    logic [11:0] v;
    v = {4'b0, addr};
    for (int k = 3; k >= 0; k--) begin
      if (v >= (12'(RAM_WORDS) << k)) v = v - (12'(RAM_WORDS) << k);
    end
    return v[RamAw-1:0];
  endfunction

  // config
  logic           file_mode_q;
  logic [7:0]     addr_mask_q;
  logic [PcW-1:0] pc_mask_q;

  // architectural state
  logic [3:0] acc_q, b_q, x_q, y_q, sx_q, sy_q;
  logic       c_q, s_q, ie_q, if0_q, if1_q, tf_q, cf_q;
  logic [PcW-1:0] stk_q [STACK_DEPTH];

  // execute stage
  logic             ex_valid_q;
  cmd_e             ex_cmd_q;
  logic [OpW-1:0]   ex_op_q;
  logic [3:0]       ex_imm_q;
  logic [PcW-1:0]   ex_pc_q;
  logic [1:0]       ex_pins_q;
  logic [RamAw-1:0] ex_addr_q;

  // data ram
  logic [3:0]           ram_q [RAM_WORDS];
  logic [RAM_WORDS-1:0] ram_vld_q;
  logic [3:0]           rd_data_q;
  logic                 rd_vld_q;
  logic                 fwd_q;
  logic [3:0]           fwd_data_q;

  // result
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic adv, in_xfer;
  assign adv           = ex_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !ex_valid_q || adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // execute logic
  logic [3:0] m;
  logic [3:0] acc_x, b_x, x_x, y_x, sx_x, sy_x;
  logic       c_x, s_x, ie_x, if0_x, if1_x, tf_x, cf_x;
  logic [PcW-1:0] stk_x [STACK_DEPTH];
  logic [PcW-1:0] npc;
  logic       blk;
  logic       mem_we_c;
  logic [3:0] mem_wdata;
  logic       do_swap;
  logic [4:0] sum5;
  logic [4:0] sub5;
  logic [3:0] tmp4;
  logic [PcW-1:0] tbr;

  assign m = fwd_q ? fwd_data_q : (rd_vld_q ? rd_data_q : 4'd0);

  always_comb begin
    acc_x = acc_q; b_x = b_q; x_x = x_q; y_x = y_q; sx_x = sx_q; sy_x = sy_q;
    c_x = c_q; s_x = s_q; ie_x = ie_q; if0_x = if0_q; if1_x = if1_q;
    tf_x = tf_q; cf_x = cf_q;
    for (int i = 0; i < STACK_DEPTH; i++) stk_x[i] = stk_q[i];
    npc = ex_pc_q;
    blk = 1'b0;
    mem_we_c = 1'b0;
    mem_wdata = 4'd0;
    do_swap = 1'b0;
    sum5 = 5'd0;
    sub5 = 5'd0;
    tmp4 = 4'd0;
    tbr = ({ex_pc_q[PcW-1:6], 6'b0} |
           {1'b0, ex_op_q[2:0], c_q, b_q, acc_q}) & pc_mask_q & PcwMask;
    case (ex_cmd_q)
      CMD_LAB:   acc_x = b_q;
      CMD_LBA:   b_x = acc_q;
      CMD_LAY:   acc_x = y_q;
      CMD_LASPX: acc_x = sx_q;
      CMD_LASPY: acc_x = sy_q;
      CMD_XAMR: begin
        acc_x = m; mem_we_c = 1'b1; mem_wdata = acc_q;
      end
      CMD_LXA:   x_x = acc_q;
      CMD_LYA:   y_x = acc_q;
      CMD_LXI:   x_x = ex_imm_q;
      CMD_LYI:   y_x = ex_imm_q;
      CMD_IY: begin
        y_x = y_q + 4'd1; s_x = (y_x != 4'd0);
      end
      CMD_DY: begin
        y_x = y_q - 4'd1; s_x = (y_x != 4'hf);
      end
      CMD_AYY: begin
        sum5 = {1'b0, y_q} + {1'b0, acc_q}; s_x = sum5[4]; y_x = sum5[3:0];
      end
      CMD_SYY: begin
        s_x = (y_q >= acc_q); y_x = y_q - acc_q;
      end
      CMD_XSP: do_swap = 1'b1;
      CMD_LAM: begin
        acc_x = m; do_swap = 1'b1;
      end
      CMD_LBM: begin
        b_x = m; do_swap = 1'b1;
      end
      CMD_XMA: begin
        acc_x = m; mem_we_c = 1'b1; mem_wdata = acc_q; do_swap = 1'b1;
      end
      CMD_XMB: begin
        b_x = m; mem_we_c = 1'b1; mem_wdata = b_q; do_swap = 1'b1;
      end
      CMD_LMAIY: begin
        mem_we_c = 1'b1; mem_wdata = acc_q; y_x = y_q + 4'd1;
        s_x = (y_x != 4'd0); do_swap = 1'b1;
      end
      CMD_LMADY: begin
        mem_we_c = 1'b1; mem_wdata = acc_q; y_x = y_q - 4'd1;
        s_x = (y_x != 4'hf); do_swap = 1'b1;
      end
      CMD_LMIIY: begin
        mem_we_c = 1'b1; mem_wdata = ex_imm_q; y_x = y_q + 4'd1;
        s_x = (y_x != 4'd0);
      end
      CMD_LAI:   acc_x = ex_imm_q;
      CMD_LBI:   b_x = ex_imm_q;
      CMD_AI: begin
        sum5 = {1'b0, acc_q} + {1'b0, ex_imm_q}; s_x = sum5[4]; acc_x = sum5[3:0];
      end
      CMD_IB: begin
        b_x = b_q + 4'd1; s_x = (b_x != 4'd0);
      end
      CMD_DB: begin
        b_x = b_q - 4'd1; s_x = (b_x != 4'hf);
      end
      CMD_AMC: begin
        sum5 = {1'b0, acc_q} + {1'b0, m} + {4'd0, c_q};
        c_x = sum5[4]; s_x = sum5[4]; acc_x = sum5[3:0];
      end
      CMD_SMC: begin
        sub5 = {1'b0, acc_q} + {4'd0, !c_q};
        c_x = ({1'b0, m} >= sub5); s_x = c_x;
        tmp4 = m - sub5[3:0];
        acc_x = tmp4;
      end
      CMD_AM: begin
        sum5 = {1'b0, acc_q} + {1'b0, m}; s_x = sum5[4]; acc_x = sum5[3:0];
      end
      CMD_DAA: begin
        if (c_q || acc_q > 4'd9) begin
          acc_x = acc_q + 4'd6; c_x = 1'b1;
        end
      end
      CMD_DAS: begin
        if (!c_q || acc_q > 4'd9) begin
          acc_x = acc_q + 4'd10; c_x = 1'b0;
        end
      end
      CMD_NEGA:  acc_x = 4'd0 - acc_q;
      CMD_COMB:  b_x = ~b_q;
      CMD_SEC:   c_x = 1'b1;
      CMD_REC:   c_x = 1'b0;
      CMD_TC:    s_x = c_q;
      CMD_ROTL: begin
        c_x = acc_q[3]; acc_x = {acc_q[2:0], c_q};
      end
      CMD_ROTR: begin
        c_x = acc_q[0]; acc_x = {c_q, acc_q[3:1]};
      end
      CMD_OR:    acc_x = acc_q | b_q;
      CMD_MNEI:  s_x = (ex_imm_q != m);
      CMD_YNEI:  s_x = (y_q != ex_imm_q);
      CMD_ANEM:  s_x = (acc_q != m);
      CMD_BNEM:  s_x = (b_q != m);
      CMD_ALEI:  s_x = (acc_q <= ex_imm_q);
      CMD_ALEM:  s_x = (acc_q <= m);
      CMD_BLEM:  s_x = (b_q <= m);
      CMD_SEM: begin
        mem_we_c = 1'b1; mem_wdata = m | (4'd1 << ex_op_q[1:0]);
      end
      CMD_REM: begin
        mem_we_c = 1'b1; mem_wdata = m & ~(4'd1 << ex_op_q[1:0]);
      end
      CMD_TM:    s_x = m[ex_op_q[1:0]];
      CMD_BR: begin
        if (s_q) npc = {ex_pc_q[PcW-1:6], ex_op_q[5:0]} & PcwMask;
        else s_x = 1'b1;
      end
      CMD_CAL: begin
        if (s_q) begin
          blk = 1'b1;
          for (int i = STACK_DEPTH - 1; i >= 1; i--) stk_x[i] = stk_q[i-1];
          stk_x[0] = ex_pc_q;
          npc = {{(PcW-6){1'b0}}, ex_op_q[5:0]} & PcwMask;
        end else begin
          s_x = 1'b1;
        end
      end
      CMD_TBR:   npc = tbr;
      CMD_RTN, CMD_RTNI: begin
        npc = stk_q[0] & pc_mask_q & PcwMask;
        for (int i = 0; i < STACK_DEPTH - 1; i++) stk_x[i] = stk_q[i+1];
        if (ex_cmd_q == CMD_RTNI) ie_x = 1'b1;
      end
      CMD_SEIE:  ie_x = 1'b1;
      CMD_SEIF0: if0_x = 1'b1;
      CMD_SEIF1: if1_x = 1'b1;
      CMD_SETF:  tf_x = 1'b1;
      CMD_SECF:  cf_x = 1'b1;
      CMD_REIE:  ie_x = 1'b0;
      CMD_REIF0: if0_x = 1'b0;
      CMD_REIF1: if1_x = 1'b0;
      CMD_RETF:  tf_x = 1'b0;
      CMD_RECF:  cf_x = 1'b0;
      CMD_TI0:   s_x = ex_pins_q[0];
      CMD_TI1:   s_x = ex_pins_q[1];
      CMD_TIF0:  s_x = if0_q;
      CMD_TIF1:  s_x = if1_q;
      CMD_TTF:   s_x = tf_q;
      default: ;
    endcase
    if (do_swap && ex_op_q[0]) begin
      x_x = sx_q; sx_x = x_q;
    end
    if (do_swap && ex_op_q[1]) begin
      sy_x = y_x; y_x = sy_q;
    end
  end

  logic mem_we;
  assign mem_we = adv && mem_we_c;

  // read address for the incoming instruction, from the state after the one in flight
  cmd_e           in_cmd;
  logic [3:0]     x_nx, y_nx, xamr_lo;
  logic [7:0]     raw_addr;
  logic [RamAw-1:0] rd_addr;

  assign in_cmd  = cmd_e'(s_axis_tdata[CmdW-1:0]);
  assign x_nx    = adv ? x_x : x_q;
  assign y_nx    = adv ? y_x : y_q;
  assign xamr_lo = s_axis_tdata[CmdW +: 4];

  always_comb begin
    if (in_cmd == CMD_XAMR) begin
      if (file_mode_q) begin
        raw_addr = (xamr_lo < 4'd4) ? {xamr_lo, xamr_lo} : {4'h4, xamr_lo};
      end else begin
        raw_addr = {4'hf, xamr_lo};
      end
    end else begin
      raw_addr = {x_nx, y_nx};
    end
  end
  assign rd_addr = ram_wrap(raw_addr & addr_mask_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) ram_q[ex_addr_q] <= mem_wdata;
    if (in_xfer) begin
      rd_data_q  <= ram_q[rd_addr];
      fwd_data_q <= mem_wdata;
      ex_cmd_q   <= in_cmd;
      ex_op_q    <= s_axis_tdata[CmdW +: OpW];
      ex_imm_q   <= s_axis_tdata[CmdW+OpW +: NibW];
      ex_pc_q    <= s_axis_tdata[CmdW+OpW+NibW +: PcW] & PcwMask;
      ex_pins_q  <= s_axis_tdata[CmdW+OpW+NibW+PcW +: 2];
      ex_addr_q  <= rd_addr;
    end
    if (adv) begin
      out_data_q <= {blk, c_x, s_x, b_x, acc_x, npc};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      fwd_q       <= 1'b0;
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      file_mode_q <= 1'b0;
      addr_mask_q <= 8'hff;
      pc_mask_q   <= {PcW{1'b1}};
      acc_q <= '0; b_q <= '0; x_q <= '0; y_q <= '0; sx_q <= '0; sy_q <= '0;
      c_q <= 1'b0; s_q <= 1'b0; ie_q <= 1'b0; if0_q <= 1'b0; if1_q <= 1'b0;
      tf_q <= 1'b0; cf_q <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_RAM_FILE_MODE: file_mode_q <= cfg_data_i[0];
          CFG_RAM_ADDR_MASK: addr_mask_q <= cfg_data_i[7:0];
          CFG_PC_MASK:       pc_mask_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (mem_we) ram_vld_q[ex_addr_q] <= 1'b1;
      if (in_xfer) begin
        rd_vld_q <= ram_vld_q[rd_addr];
        fwd_q    <= mem_we && (ex_addr_q == rd_addr);
      end
      if (in_xfer) ex_valid_q <= 1'b1;
      else if (adv) ex_valid_q <= 1'b0;
      if (adv) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (adv) begin
        acc_q <= acc_x; b_q <= b_x; x_q <= x_x; y_q <= y_x; sx_q <= sx_x; sy_q <= sy_x;
        c_q <= c_x; s_q <= s_x; ie_q <= ie_x; if0_q <= if0_x; if1_q <= if1_x;
        tf_q <= tf_x; cf_q <= cf_x;
        for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= stk_x[i];
      end
    end
  end

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ex_valid_q |-> s_axis_tready) else $error("input not ready with empty stage");

  a_fwd_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && mem_we && ex_addr_q == rd_addr) |=> fwd_q)
    else $error("same-edge ram write not forwarded");

  a_ex_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_valid_q && !adv) |=> (ex_valid_q && $stable(ex_addr_q)))
    else $error("stalled instruction lost");

  a_blk_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && blk) |-> (ex_cmd_q == CMD_CAL && s_q))
    else $error("interrupt block without taken call");

endmodule

[tb/four_bit_mcu_execute_unit_tb.sv]
`timescale 1ns / 1ps

module four_bit_mcu_execute_unit_tb;
  import fbmeu_pkg::*;

  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic            blk;
    logic            c;
    logic            s;
    logic [NibW-1:0] breg;
    logic [NibW-1:0] acc;
    logic [PcW-1:0]  next_pc;
  } mcu_result_t;

  typedef struct {
    logic [CmdW-1:0] cmd;
    logic [OpW-1:0]  op;
    logic [NibW-1:0] imm;
    logic [PcW-1:0]  pc;
    logic [1:0]      pins;
    bit              fixed;
    mcu_result_t     res;
  } instr_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  four_bit_mcu_execute_unit u_top (.*);

  // predictor state
  logic       mdl_file_mode;
  logic [7:0] mdl_addr_mask;
  logic [PcW-1:0] mdl_pc_mask;
  logic [3:0] ra, rb, rx, ry, rsx, rsy;
  logic c_f, s_f, ie_f, if0_f, if1_f, tf_f, cf_f;
  logic [PcW-1:0] ret_stack [4];
  logic [3:0] dram [256];

  mcu_result_t exp_results [$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic logic [7:0] ram_addr(logic [7:0] a);
    return a & mdl_addr_mask;
  endfunction

  function automatic logic [3:0] rd_mem();
    return dram[ram_addr({rx, ry})];
  endfunction

  function automatic void wr_mem(logic [3:0] v);
    dram[ram_addr({rx, ry})] = v;
  endfunction

  function automatic void swap_pair(logic [OpW-1:0] op);
    logic [3:0] t;
    if (op[0]) begin
      t = rx; rx = rsx; rsx = t;
    end
    if (op[1]) begin
      t = ry; ry = rsy; rsy = t;
    end
  endfunction

  function automatic void y_up();
    ry = ry + 4'd1;
    s_f = (ry != 4'd0);
  endfunction

  function automatic void y_down();
    ry = ry - 4'd1;
    s_f = (ry != 4'hf);
  endfunction

  function automatic logic [PcW-1:0] ret_pop();
    logic [PcW-1:0] v;
    v = ret_stack[0] & mdl_pc_mask;
    for (int i = 0; i < 3; i++) ret_stack[i] = ret_stack[i+1];
    return v;
  endfunction

  function automatic void reset_mcu_state();
    mdl_file_mode = 1'b0;
    mdl_addr_mask = 8'hff;
    mdl_pc_mask = '1;
    {ra, rb, rx, ry, rsx, rsy} = '0;
    {c_f, s_f, ie_f, if0_f, if1_f, tf_f, cf_f} = '0;
    foreach (ret_stack[i]) ret_stack[i] = '0;
    foreach (dram[i]) dram[i] = '0;
  endfunction

  function automatic mcu_result_t execute_instr(logic [6:0] cmd, logic [OpW-1:0] op,
                                                logic [3:0] imm, logic [PcW-1:0] pc,
                                                logic [1:0] pins);
    mcu_result_t r;
    logic [PcW-1:0] npc;
    logic [4:0] t;
    logic [3:0] m, tmp;
    logic [7:0] a;
    logic blk;
    npc = pc;
    blk = 1'b0;
    case (cmd)
      CMD_LAB: ra = rb;
      CMD_LBA: rb = ra;
      CMD_LAY: ra = ry;
      CMD_LASPX: ra = rsx;
      CMD_LASPY: ra = rsy;
      CMD_XAMR: begin
        a = {4'h0, op[3:0]};
        if (mdl_file_mode) a = a | ((op[3:0] < 4) ? {op[3:0], 4'h0} : 8'h40);
        else a = a | 8'hf0;
        a = ram_addr(a);
        tmp = ra; ra = dram[a]; dram[a] = tmp;
      end
      CMD_LXA: rx = ra;
      CMD_LYA: ry = ra;
      CMD_LXI: rx = imm;
      CMD_LYI: ry = imm;
      CMD_IY: y_up();
      CMD_DY: y_down();
      CMD_AYY: begin
        t = ry + ra; s_f = t[4]; ry = t[3:0];
      end
      CMD_SYY: begin
        s_f = (ry >= ra); ry = ry - ra;
      end
      CMD_XSP: swap_pair(op);
      CMD_LAM: begin ra = rd_mem(); swap_pair(op); end
      CMD_LBM: begin rb = rd_mem(); swap_pair(op); end
      CMD_XMA: begin tmp = ra; ra = rd_mem(); wr_mem(tmp); swap_pair(op); end
      CMD_XMB: begin tmp = rb; rb = rd_mem(); wr_mem(tmp); swap_pair(op); end
      CMD_LMAIY: begin wr_mem(ra); y_up(); swap_pair(op); end
      CMD_LMADY: begin wr_mem(ra); y_down(); swap_pair(op); end
      CMD_LMIIY: begin wr_mem(imm); y_up(); end
      CMD_LAI: ra = imm;
      CMD_LBI: rb = imm;
      CMD_AI: begin t = ra + imm; s_f = t[4]; ra = t[3:0]; end
      CMD_IB: begin rb = rb + 4'd1; s_f = (rb != 4'd0); end
      CMD_DB: begin rb = rb - 4'd1; s_f = (rb != 4'hf); end
      CMD_AMC: begin
        t = ra + rd_mem() + c_f; c_f = t[4]; s_f = t[4]; ra = t[3:0];
      end
      CMD_SMC: begin
        m = rd_mem(); t = ra + !c_f;
        c_f = ({1'b0, m} >= t); s_f = c_f; ra = m - t[3:0];
      end
      CMD_AM: begin t = ra + rd_mem(); s_f = t[4]; ra = t[3:0]; end
      CMD_DAA: if (c_f || ra > 9) begin ra = ra + 4'd6; c_f = 1'b1; end
      CMD_DAS: if (!c_f || ra > 9) begin ra = ra + 4'd10; c_f = 1'b0; end
      CMD_NEGA: ra = -ra;
      CMD_COMB: rb = ~rb;
      CMD_SEC: c_f = 1'b1;
      CMD_REC: c_f = 1'b0;
      CMD_TC: s_f = c_f;
      CMD_ROTL: begin t = {ra, c_f}; c_f = t[4]; ra = t[3:0]; end
      CMD_ROTR: begin tmp = ra; ra = {c_f, ra[3:1]}; c_f = tmp[0]; end
      CMD_OR: ra = ra | rb;
      CMD_MNEI: s_f = (imm != rd_mem());
      CMD_YNEI: s_f = (ry != imm);
      CMD_ANEM: s_f = (ra != rd_mem());
      CMD_BNEM: s_f = (rb != rd_mem());
      CMD_ALEI: s_f = (ra <= imm);
      CMD_ALEM: s_f = (ra <= rd_mem());
      CMD_BLEM: s_f = (rb <= rd_mem());
      CMD_SEM: begin m = rd_mem(); m[op[1:0]] = 1'b1; wr_mem(m); end
      CMD_REM: begin m = rd_mem(); m[op[1:0]] = 1'b0; wr_mem(m); end
      CMD_TM: begin m = rd_mem(); s_f = m[op[1:0]]; end
      CMD_BR: if (s_f) npc = {pc[PcW-1:6], op[5:0]}; else s_f = 1'b1;
      CMD_CAL: if (s_f) begin
        blk = 1'b1;
        for (int i = 3; i >= 1; i--) ret_stack[i] = ret_stack[i-1];
        ret_stack[0] = pc;
        npc = {7'd0, op[5:0]};
      end else s_f = 1'b1;
      CMD_TBR: npc = ({pc[PcW-1:6], 6'd0} | {1'b0, op[2:0], c_f, rb, ra}) & mdl_pc_mask;
      CMD_RTN: npc = ret_pop();
      CMD_SEIE: ie_f = 1'b1;
      CMD_SEIF0: if0_f = 1'b1;
      CMD_SEIF1: if1_f = 1'b1;
      CMD_SETF: tf_f = 1'b1;
      CMD_SECF: cf_f = 1'b1;
      CMD_REIE: ie_f = 1'b0;
      CMD_REIF0: if0_f = 1'b0;
      CMD_REIF1: if1_f = 1'b0;
      CMD_RETF: tf_f = 1'b0;
      CMD_RECF: cf_f = 1'b0;
      CMD_TI0: s_f = pins[0];
      CMD_TI1: s_f = pins[1];
      CMD_TIF0: s_f = if0_f;
      CMD_TIF1: s_f = if1_f;
      CMD_TTF: s_f = tf_f;
      CMD_RTNI: begin ie_f = 1'b1; npc = ret_pop(); end
      default: ;
    endcase
    r.next_pc = npc;
    r.acc = ra;
    r.breg = rb;
    r.s = s_f;
    r.c = c_f;
    r.blk = blk;
    return r;
  endfunction

  // driver
  task automatic send_instr(logic [6:0] cmd, logic [OpW-1:0] op, logic [3:0] imm,
                            logic [PcW-1:0] pc, logic [1:0] pins, bit fixed,
                            mcu_result_t fixed_res);
    mcu_result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW-36){1'b0}}, pins, pc, imm, op, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = execute_instr(cmd, op, imm, pc, pins);
    if (fixed && r != fixed_res) begin
      $display("%0t directed row mismatch: expected %h actual model %h", $time, fixed_res, r);
      errors++;
    end
    exp_results.push_back(r);
  endtask

  task automatic gap_or_continue();
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_idle();
    s_axis_tvalid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RAM_FILE_MODE: mdl_file_mode = val[0];
      CFG_RAM_ADDR_MASK: mdl_addr_mask = val[7:0];
      default: mdl_pc_mask = val;
    endcase
    @(posedge clk_i);
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (($time / 700) % 3 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 2) != 0);
  end

  // result checker
  always @(posedge clk_i) begin
    mcu_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(mcu_result_t)-1:0];
      if (exp_results.size() == 0) begin
        $display("%0t unexpected transfer: expected none actual %h", $time, got);
        errors++;
      end else begin
        want = exp_results.pop_front();
        if (got.next_pc !== want.next_pc) begin
          $display("%0t next_pc: expected %h actual %h", $time, want.next_pc, got.next_pc);
          errors++;
        end
        if (got.acc !== want.acc) begin
          $display("%0t acc: expected %h actual %h", $time, want.acc, got.acc);
          errors++;
        end
        if (got.breg !== want.breg) begin
          $display("%0t breg: expected %h actual %h", $time, want.breg, got.breg);
          errors++;
        end
        if (got.s !== want.s) begin
          $display("%0t status: expected %b actual %b", $time, want.s, got.s);
          errors++;
        end
        if (got.c !== want.c) begin
          $display("%0t carry: expected %b actual %b", $time, want.c, got.c);
          errors++;
        end
        if (got.blk !== want.blk) begin
          $display("%0t block_int: expected %b actual %b", $time, want.blk, got.blk);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else if (exp_results.size() != 0 || s_axis_tvalid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic mcu_result_t mk_res(logic [PcW-1:0] npc, logic [3:0] a,
                                         logic [3:0] b, logic s, logic c, logic blk);
    mcu_result_t r;
    r.next_pc = npc; r.acc = a; r.breg = b; r.s = s; r.c = c; r.blk = blk;
    return r;
  endfunction

  task automatic random_instr(int lo, int hi);
    logic [6:0] cmd;
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) cmd = 7'($urandom_range(71, 127));
    else if (sel < 4) cmd = 7'($urandom_range(11, 22));
    else cmd = 7'($urandom_range(lo, hi));
    send_instr(cmd, OpW'($urandom()), 4'($urandom()), PcW'($urandom()), 2'($urandom()),
               1'b0, '0);
    gap_or_continue();
  endtask

  instr_row_t dir_rows [$];

  initial begin
    instr_row_t row;
    int burst;
    reset_mcu_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    dir_rows = '{
      '{CMD_ILL, '0, 4'h0, 13'h0000, 2'b00, 1'b1,
        mk_res(13'h0000, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0)},
      '{CMD_LAI, '1, 4'hf, 13'h1fff, 2'b11, 1'b1,
        mk_res(13'h1fff, 4'hf, 4'h0, 1'b0, 1'b0, 1'b0)},
      '{CMD_LBI, '0, 4'h9, 13'h0010, 2'b00, 1'b1,
        mk_res(13'h0010, 4'hf, 4'h9, 1'b0, 1'b0, 1'b0)},
      '{CMD_AI, '0, 4'h1, 13'h0001, 2'b00, 1'b1,
        mk_res(13'h0001, 4'h0, 4'h9, 1'b1, 1'b0, 1'b0)},
      '{CMD_SEC, '0, 4'h0, 13'h0002, 2'b00, 1'b1,
        mk_res(13'h0002, 4'h0, 4'h9, 1'b1, 1'b1, 1'b0)},
      '{CMD_CAL, 10'h3ff, 4'h0, 13'h1abc, 2'b00, 1'b1,
        mk_res(13'h003f, 4'h0, 4'h9, 1'b1, 1'b1, 1'b1)},
      '{CMD_RTN, '0, 4'h0, 13'h0000, 2'b00, 1'b1,
        mk_res(13'h1abc, 4'h0, 4'h9, 1'b1, 1'b1, 1'b0)},
      '{CMD_TI0, '0, 4'h0, 13'h0005, 2'b01, 1'b1,
        mk_res(13'h0005, 4'h0, 4'h9, 1'b1, 1'b1, 1'b0)},
      '{CMD_TI1, '0, 4'h0, 13'h0005, 2'b01, 1'b1,
        mk_res(13'h0005, 4'h0, 4'h9, 1'b0, 1'b1, 1'b0)},
      '{7'd127, '1, 4'hf, 13'h1fff, 2'b11, 1'b1,
        mk_res(13'h1fff, 4'h0, 4'h9, 1'b0, 1'b1, 1'b0)},
      '{CMD_LXI, '0, 4'hf, '0, 2'b00, 1'b0, '0},
      '{CMD_LYI, '0, 4'hf, '0, 2'b00, 1'b0, '0},
      '{CMD_LMIIY, '0, 4'ha, '0, 2'b00, 1'b0, '0},
      '{CMD_DY, '0, 4'h0, '0, 2'b00, 1'b0, '0},
      '{CMD_AMC, '0, 4'h0, '0, 2'b00, 1'b0, '0},
      '{CMD_SMC, '0, 4'h0, '0, 2'b00, 1'b0, '0},
      '{CMD_DAA, '0, 4'h0, '0, 2'b00, 1'b0, '0},
      '{CMD_DAS, '0, 4'h0, '0, 2'b00, 1'b0, '0},
      '{CMD_XAMR, 10'h003, 4'h0, '0, 2'b00, 1'b0, '0},
      '{CMD_SEM, 10'h003, 4'h0, '0, 2'b00, 1'b0, '0},
      '{CMD_TM, 10'h003, 4'h0, '0, 2'b00, 1'b0, '0},
      '{CMD_TBR, 10'h007, 4'h0, 13'h1fc0, 2'b00, 1'b0, '0},
      '{CMD_RTNI, '0, 4'h0, '0, 2'b00, 1'b0, '0},
      '{CMD_XSP, 10'h003, 4'h0, '0, 2'b00, 1'b0, '0}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_instr(row.cmd, row.op, row.imm, row.pc, row.pins, row.fixed, row.res);
    end
    drain_and_idle();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_cfg(CFG_RAM_FILE_MODE, 13'd1);
          write_cfg(CFG_RAM_ADDR_MASK, 13'd0);
          write_cfg(CFG_PC_MASK, 13'd0);
        end
        2: begin
          write_cfg(CFG_RAM_ADDR_MASK, 13'h0ff);
          write_cfg(CFG_PC_MASK, 13'h1fff);
        end
        3: begin
          write_cfg(CFG_RAM_FILE_MODE, 13'd0);
          write_cfg(CFG_RAM_ADDR_MASK, CfgDataW'($urandom_range(0, 255)));
          write_cfg(CFG_PC_MASK, CfgDataW'($urandom_range(0, 8191)));
        end
        4: begin
          write_cfg(CFG_RAM_FILE_MODE, 13'd1);
          write_cfg(CFG_RAM_ADDR_MASK, 13'h00f);
        end
        5: begin
          write_cfg(CFG_RAM_ADDR_MASK, 13'h0ff);
          write_cfg(CFG_PC_MASK, 13'h1fff);
        end
        default: ;
      endcase
      for (int n = 0; n < 300; ) begin
        burst = $urandom_range(1, 30);
        for (int k = 0; k < burst; k++) begin
          send_instr(7'($urandom_range(0, 70)), OpW'($urandom()), 4'($urandom()),
                     PcW'($urandom()), 2'($urandom()), 1'b0, '0);
          n++;
        end
        if ($urandom_range(0, 1)) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
        for (int k = 0; k < 4; k++) random_instr(0, 70);
        n += 4;
      end
      drain_and_idle();
    end

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
